// File: design/assert_macros.svh
// Assertion macros shared by the sparse matrix-vector multiplier RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPMV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spmv assertion failed");
`define SPMV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("spmv forbidden condition");
`else
`define SPMV_ASSERT(lbl, prop)
`define SPMV_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: design/spmv_pkg.sv
// Types and constants of the CSR sparse matrix-vector multiplier.
// No dependencies; used by the top-level design file and the testbench.
package spmv_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_e;

  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CFG_COLUMN_COUNT = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_ROW_COUNT    = 1'd1;

  localparam int ColCountW = 11;
  localparam int RowW      = 16;
  localparam int PosW      = 10;
  localparam int InValW    = 32;
  localparam int SumW      = 64;

  localparam logic [ColCountW-1:0] COLUMN_COUNT_RST = 11'd1024;
  localparam logic [RowW-1:0]      ROW_COUNT_RST    = 16'd1;

  typedef struct packed {
    logic [1:0]               kind;
    logic [PosW-1:0]          position;
    logic signed [InValW-1:0] element_value;
    logic                     row_end;
  } in_t;

  typedef struct packed {
    logic [RowW-1:0]        row_number;
    logic signed [SumW-1:0] row_sum;
    logic                   column_error;
    logic                   last_row;
  } out_t;

endpackage

// File: design/spmv_vec_mem.sv
// Vector element store: one write port, one read port with registered data.
// Uses no package items.
module spmv_vec_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix-vector multiplier.
// Depends on spmv_pkg, spmv_vec_mem and assert_macros.svh.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   spmv_pkg::in_t
//   out      output     out_valid_o / out_stall_i spmv_pkg::out_t
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One transaction per cycle unless in_stall_o is high; row sums are registered.
// Stages: vector read, 32x32 multiply, saturating 64-bit accumulate/output reg.
// Stages advance independently, so input keeps flowing into empty stages while
// a result waits; in_stall_o rises only when all stages are held.
// Reset clears control and accumulator; the vector store is not cleared.
`include "assert_macros.svh"

module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  spmv_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output spmv_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [spmv_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [spmv_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int AW   = (VECTOR_DEPTH > 2) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int ExtW = (AW > spmv_pkg::PosW) ? AW : spmv_pkg::PosW;
  localparam int VW   = VALUE_WIDTH;

  // configuration
  logic [spmv_pkg::ColCountW-1:0] col_count_q;
  logic [spmv_pkg::RowW-1:0]      row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= spmv_pkg::COLUMN_COUNT_RST;
      row_count_q <= spmv_pkg::ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spmv_pkg::CFG_COLUMN_COUNT: col_count_q <= cfg_wdata_i[spmv_pkg::ColCountW-1:0];
        spmv_pkg::CFG_ROW_COUNT:    row_count_q <= cfg_wdata_i[spmv_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic v1_q, v2_q, out_v_q;
  logic s2_close_q;
  logic take, out_free, s2_go, s2_free, s1_go, s1_free, in_acc;

  assign take     = out_v_q && !out_stall_i;
  assign out_free = !out_v_q || take;
  assign s2_go    = v2_q && (!s2_close_q || out_free);
  assign s2_free  = !v2_q || s2_go;
  assign s1_go    = v1_q && s2_free;
  assign s1_free  = !v1_q || s1_go;
  assign in_stall_o = !s1_free;
  assign in_acc   = in_valid_i && s1_free;

  // input decode
  logic [ExtW-1:0]      pos_ext;
  logic [AW-1:0]        addr;
  logic                 pos_in_depth;
  logic                 is_load, is_nz, is_empty, s1_load, col_ok;
  logic signed [VW-1:0] in_val;

  assign pos_ext      = ExtW'(in_data_i.position);
  assign addr         = pos_ext[AW-1:0];
  assign pos_in_depth = 32'(in_data_i.position) < VECTOR_DEPTH;
  assign in_val       = in_data_i.element_value[VW-1:0];
  assign is_load      = in_data_i.kind == spmv_pkg::KIND_LOAD;
  assign is_nz        = in_data_i.kind == spmv_pkg::KIND_NONZERO;
  assign is_empty     = in_data_i.kind == spmv_pkg::KIND_EMPTY;
  assign s1_load      = in_acc && (is_nz || is_empty);
  assign col_ok       = pos_in_depth &&
                        (spmv_pkg::ColCountW'(in_data_i.position) < col_count_q);

  logic [VW-1:0] vec_rdata;

  spmv_vec_mem #(
    .DEPTH (VECTOR_DEPTH),
    .WIDTH (VW),
    .AW    (AW)
  ) u_vec_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_load && pos_in_depth),
    .waddr_i (addr),
    .wdata_i (in_val),
    .re_i    (s1_load),
    .raddr_i (addr),
    .rdata_o (vec_rdata)
  );

  // stage 1: operand register
  logic                 s1_nz_q, s1_close_q, s1_ok_q;
  logic signed [VW-1:0] s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_load) begin
      v1_q <= 1'b1;
    end else if (s1_go) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_nz_q    <= is_nz;
      s1_close_q <= is_empty || in_data_i.row_end;
      s1_ok_q    <= is_nz && col_ok;
      s1_val_q   <= in_val;
    end
  end

  // stage 2: product register
  logic signed [2*VW-1:0]          prod_w;
  logic signed [spmv_pkg::SumW-1:0] s2_prod_q;
  logic                            s2_bad_q;

  assign prod_w = $signed(vec_rdata) * s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s1_go) begin
      v2_q <= 1'b1;
    end else if (s2_go) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_prod_q  <= s1_ok_q ? spmv_pkg::SumW'(prod_w) : '0;
      s2_bad_q   <= s1_nz_q && !s1_ok_q;
      s2_close_q <= s1_close_q;
    end
  end

  // stage 3: accumulate and result register
  logic signed [spmv_pkg::SumW-1:0] acc_q, acc_sum;
  logic [spmv_pkg::SumW:0]          sum_w;
  logic                             err_q, err_now, last_now;
  logic [spmv_pkg::RowW-1:0]        cur_row_q;
  logic [spmv_pkg::RowW:0]          row_inc;
  spmv_pkg::out_t                   out_q;

  assign sum_w   = {acc_q[spmv_pkg::SumW-1], acc_q} +
                   {s2_prod_q[spmv_pkg::SumW-1], s2_prod_q};
  assign acc_sum = (sum_w[spmv_pkg::SumW] != sum_w[spmv_pkg::SumW-1]) ?
                   {sum_w[spmv_pkg::SumW], {(spmv_pkg::SumW-1){!sum_w[spmv_pkg::SumW]}}} :
                   sum_w[spmv_pkg::SumW-1:0];
  assign err_now  = err_q || s2_bad_q;
  assign row_inc  = {1'b0, cur_row_q} + 1'b1;
  assign last_now = row_inc >= {1'b0, row_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      err_q     <= 1'b0;
      cur_row_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (s2_go) begin
        if (s2_close_q) begin
          acc_q     <= '0;
          err_q     <= 1'b0;
          cur_row_q <= last_now ? '0 : row_inc[spmv_pkg::RowW-1:0];
        end else begin
          acc_q <= acc_sum;
          err_q <= err_now;
        end
      end
      if (s2_go && s2_close_q) begin
        out_v_q <= 1'b1;
      end else if (take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_close_q) begin
      out_q.row_number   <= cur_row_q;
      out_q.row_sum      <= acc_sum;
      out_q.column_error <= err_now;
      out_q.last_row     <= last_now;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `SPMV_ASSERT(a_s1_holds, (v1_q && !s1_go) |=> v1_q)
  `SPMV_ASSERT(a_out_from_close, $rose(out_v_q) |-> $past(s2_go && s2_close_q))
  `SPMV_ASSERT(a_close_clears, (s2_go && s2_close_q) |=> (acc_q == '0 && !err_q))
  `SPMV_ASSERT(a_last_wraps, (s2_go && s2_close_q && last_now) |=> cur_row_q == '0)
  `SPMV_ASSERT_NEVER(a_last_row_early,
    out_v_q && out_q.last_row &&
    (({1'b0, out_q.row_number} + 1'b1) < {1'b0, row_count_q}))

endmodule

// File: tb/csr_sparse_matrix_vector_multiply_tb.sv
// Testbench for csr_sparse_matrix_vector_multiply: directed and random vector loads,
// row streams and register settings, checked against a row-sum predictor under backpressure.
// Depends on spmv_pkg and the csr_sparse_matrix_vector_multiply RTL.
`timescale 1ns / 100ps

module csr_sparse_matrix_vector_multiply_tb;

  localparam int VEC_DEPTH = 1024;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [spmv_pkg::SumW-1:0] SUM_MAX = {1'b0, {(spmv_pkg::SumW-1){1'b1}}};
  localparam logic signed [spmv_pkg::SumW-1:0] SUM_MIN = {1'b1, {(spmv_pkg::SumW-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  spmv_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  spmv_pkg::out_t out_data_o;
  logic cfg_we_i;
  logic [spmv_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [spmv_pkg::CfgDataW-1:0] cfg_wdata_i;

  // predictor state
  logic signed [spmv_pkg::InValW-1:0] vec_mirror [VEC_DEPTH];
  logic signed [spmv_pkg::SumW-1:0] acc_mirror;
  logic [spmv_pkg::RowW-1:0] row_mirror;
  logic err_mirror;
  logic [spmv_pkg::ColCountW-1:0] col_count_mirror;
  logic [spmv_pkg::RowW-1:0] row_count_mirror;

  spmv_pkg::out_t row_sums_due [$];
  spmv_pkg::out_t sum_due;
  logic [spmv_pkg::PosW-1:0] loaded_cols [$];
  bit col_loaded [VEC_DEPTH];

  bit quiet;
  bit hold_req;
  int unsigned stall_len;
  int unsigned mismatches, sums_checked, sat_rows, err_rows, cfg_writes;
  int unsigned n_loads, n_nonzeros, n_markers, n_unused;

  csr_sparse_matrix_vector_multiply uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [spmv_pkg::InValW-1:0] random_value();
    logic [spmv_pkg::InValW-1:0] v;
    case ($urandom_range(0, 7)) inside
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      [2:3]: begin
        v = $urandom_range(0, 32'h0002_0000);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [spmv_pkg::PosW-1:0] load_position();
    int unsigned span;
    span = (col_count_mirror > VEC_DEPTH) ? VEC_DEPTH : col_count_mirror;
    if (span == 0 || $urandom_range(0, 3) == 0)
      return spmv_pkg::PosW'($urandom_range(0, VEC_DEPTH - 1));
    return spmv_pkg::PosW'($urandom_range(0, span - 1));
  endfunction

  // Only loaded columns or out-of-range columns, so no unwritten element enters a row sum.
  function automatic logic [spmv_pkg::PosW-1:0] pick_column();
    logic [spmv_pkg::PosW-1:0] c;
    if (col_count_mirror < VEC_DEPTH && $urandom_range(0, 9) == 0)
      return spmv_pkg::PosW'($urandom_range(col_count_mirror, VEC_DEPTH - 1));
    c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    for (int i = 0; i < 4 && c >= col_count_mirror; i++)
      c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    return c;
  endfunction

  function automatic spmv_pkg::in_t make_item(logic [1:0] kind, logic [spmv_pkg::PosW-1:0] pos,
                                              logic [spmv_pkg::InValW-1:0] value,
                                              logic row_end);
    spmv_pkg::in_t item;
    item.kind = kind;
    item.position = pos;
    item.element_value = value;
    item.row_end = row_end;
    return item;
  endfunction

  task automatic predict_row_sum(spmv_pkg::in_t item);
    logic signed [spmv_pkg::SumW-1:0] prod;
    logic [spmv_pkg::SumW-1:0] op_a, op_b;
    logic [spmv_pkg::SumW:0] total;
    logic close_now;
    logic last;
    spmv_pkg::out_t rec;
    close_now = 1'b0;
    case (item.kind)
      spmv_pkg::KIND_LOAD: begin
        vec_mirror[item.position] = item.element_value;
        n_loads++;
      end
      spmv_pkg::KIND_NONZERO: begin
        n_nonzeros++;
        if ({1'b0, item.position} < col_count_mirror) begin
          op_a = {{32{vec_mirror[item.position][spmv_pkg::InValW-1]}},
                  vec_mirror[item.position]};
          op_b = {{32{item.element_value[spmv_pkg::InValW-1]}}, item.element_value};
          prod = op_a * op_b;
          total = {acc_mirror[spmv_pkg::SumW-1], acc_mirror} + {prod[spmv_pkg::SumW-1], prod};
          if (total[spmv_pkg::SumW] != total[spmv_pkg::SumW-1])
            acc_mirror = total[spmv_pkg::SumW] ? SUM_MIN : SUM_MAX;
          else acc_mirror = total[spmv_pkg::SumW-1:0];
        end else begin
          err_mirror = 1'b1;
        end
        close_now = item.row_end;
      end
      spmv_pkg::KIND_EMPTY: begin
        n_markers++;
        close_now = 1'b1;
      end
      default: n_unused++;
    endcase
    if (close_now) begin
      last = ({1'b0, row_mirror} + 17'd1) >= {1'b0, row_count_mirror};
      rec.row_number = row_mirror;
      rec.row_sum = acc_mirror;
      rec.column_error = err_mirror;
      rec.last_row = last;
      row_sums_due = {row_sums_due, rec};
      if (acc_mirror == SUM_MAX || acc_mirror == SUM_MIN) sat_rows++;
      if (err_mirror) err_rows++;
      acc_mirror = '0;
      err_mirror = 1'b0;
      row_mirror = last ? '0 : row_mirror + 1'b1;
    end
  endtask

  task automatic send_item(spmv_pkg::in_t item);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_row_sum(item);
  endtask

  task automatic send_load(logic [spmv_pkg::PosW-1:0] pos, logic [spmv_pkg::InValW-1:0] value);
    if (!col_loaded[pos]) begin
      col_loaded[pos] = 1'b1;
      loaded_cols = {loaded_cols, pos};
    end
    send_item(make_item(spmv_pkg::KIND_LOAD, pos, value, 1'($urandom_range(0, 1))));
  endtask

  task automatic drain_row_sums();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [spmv_pkg::CfgIndexW-1:0] idx,
                                logic [spmv_pkg::CfgDataW-1:0] data);
    drain_row_sums();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == spmv_pkg::CFG_COLUMN_COUNT) col_count_mirror = data[spmv_pkg::ColCountW-1:0];
    else row_count_mirror = data[spmv_pkg::RowW-1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_cases();
    write_register(spmv_pkg::CFG_COLUMN_COUNT, 16'd4);
    write_register(spmv_pkg::CFG_ROW_COUNT, 16'd3);
    send_load(10'd0, 32'h7FFF_FFFF);
    send_load(10'd1, 32'h8000_0000);
    send_load(10'd2, 32'h0001_0000);
    send_load(10'd3, 32'hFFFF_0000);
    send_load(10'd1023, 32'hA5A5_A5A5);
    send_load(10'd682, 32'h5A5A_5A5A);
    send_load(10'd341, 32'h0000_0000);
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd2, 32'h0002_0000, 1'b0));
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd3, 32'h7FFF_FFFF, 1'b1));
    // column beyond column_count still closes its row
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd1023, 32'h1234_5678, 1'b1));
    send_item(make_item(KIND_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(spmv_pkg::KIND_EMPTY, 10'd0, 32'h0, 1'b0));
    // positive then negative saturation
    repeat (2) send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd1, 32'h8000_0000, 1'b0));
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd1, 32'h8000_0000, 1'b1));
    repeat (2) send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd1, 32'h7FFF_FFFF, 1'b0));
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd1, 32'h7FFF_FFFF, 1'b1));
    // pending nonzeros closed by an empty-row marker
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd0, 32'h0, 1'b0));
    send_item(make_item(spmv_pkg::KIND_NONZERO, 10'd4, 32'hDEAD_BEEF, 1'b0));
    send_item(make_item(spmv_pkg::KIND_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1));
  endtask

  task automatic test_random_rows(logic [spmv_pkg::CfgDataW-1:0] cols,
                                  logic [spmv_pkg::CfgDataW-1:0] rows,
                                  int unsigned n_items, bit no_idle);
    int unsigned done, k, r;
    bit broken;
    write_register(spmv_pkg::CFG_COLUMN_COUNT, cols);
    write_register(spmv_pkg::CFG_ROW_COUNT, rows);
    quiet = no_idle;
    done = 10 + $urandom_range(0, 10);
    repeat (done) send_load(load_position(), random_value());
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(make_item(KIND_UNUSED, spmv_pkg::PosW'($urandom_range(0, VEC_DEPTH - 1)),
                            $urandom, 1'($urandom_range(0, 1))));
      end else if (r < 10) begin
        send_load(load_position(), random_value());
        done++;
      end else begin
        broken = (r < 18);
        k = $urandom_range(broken ? 1 : 0, 5);
        for (int i = 0; i < k; i++)
          send_item(make_item(spmv_pkg::KIND_NONZERO, pick_column(), random_value(),
                              !broken && i == k - 1));
        if (broken || k == 0) begin
          send_item(make_item(spmv_pkg::KIND_EMPTY,
                              spmv_pkg::PosW'($urandom_range(0, VEC_DEPTH - 1)), $urandom,
                              1'($urandom_range(0, 1))));
          done++;
        end
        done += k;
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver holds off while rows keep coming back to back, then the sender waits it out.
  task automatic test_output_hold();
    write_register(spmv_pkg::CFG_COLUMN_COUNT, 16'd1024);
    write_register(spmv_pkg::CFG_ROW_COUNT, 16'd7);
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 36; i++) begin
      if (i % 2 != 0) send_item(make_item(spmv_pkg::KIND_EMPTY, 10'd0, 32'h0, 1'b0));
      else send_item(make_item(spmv_pkg::KIND_NONZERO, pick_column(), random_value(), 1'b1));
    end
    drain_row_sums();
    quiet = 1'b0;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        stall_len = idle_cycles();
        if (stall_len == 0) begin
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (row_sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected row sum: row %0d sum %h err %b last %b", $time,
                   out_data_o.row_number, out_data_o.row_sum, out_data_o.column_error,
                   out_data_o.last_row);
      end else begin
        sum_due = row_sums_due.pop_front();
        sums_checked++;
        if (out_data_o.row_number !== sum_due.row_number ||
            out_data_o.row_sum !== sum_due.row_sum ||
            out_data_o.column_error !== sum_due.column_error ||
            out_data_o.last_row !== sum_due.last_row) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected row %0d sum %h err %b last %b", $time,
                     sum_due.row_number, sum_due.row_sum, sum_due.column_error,
                     sum_due.last_row);
            $display("%0t:      got row %0d sum %h err %b last %b", $time,
                     out_data_o.row_number, out_data_o.row_sum, out_data_o.column_error,
                     out_data_o.last_row);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d row sums outstanding", row_sums_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    acc_mirror = '0;
    row_mirror = '0;
    err_mirror = 1'b0;
    col_count_mirror = spmv_pkg::COLUMN_COUNT_RST;
    row_count_mirror = spmv_pkg::ROW_COUNT_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_rows(16'd1024, 16'd65535, 110, 1'b0);
    test_random_rows(16'd1, 16'd0, 80, 1'b0);
    test_random_rows(16'($urandom_range(2, 1023)), 16'($urandom_range(1, 12)), 110, 1'b1);
    test_random_rows(16'd16, 16'd4, 110, 1'b0);
    test_output_hold();

    drain_row_sums();
    $display("Sent %0d loads, %0d nonzeros, %0d row markers, %0d unused, %0d register writes",
             n_loads, n_nonzeros, n_markers, n_unused, cfg_writes);
    $display("Checked %0d row sums, %0d saturated, %0d with a dropped column, %0d mismatches",
             sums_checked, sat_rows, err_rows, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: csr_sparse_matrix_vector_multiply.f
+incdir+design
design/spmv_pkg.sv
design/spmv_vec_mem.sv
design/csr_sparse_matrix_vector_multiply.sv
tb/csr_sparse_matrix_vector_multiply_tb.sv
